[rtl/core/assert_macros.svh]
// assertion macros, used by the digit engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_HOLDS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_HOLDS(label, clk, rst_n, expr, msg)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/core/irad_pkg.sv]
// shared types, constants and tables of the radix conversion block
`default_nettype none
package irad_pkg;
	localparam int MAX_RADIX = 32;
	localparam int MAX_DIGITS = 32;
	localparam int NUM_W = 32;
	localparam int CHAR_W = 8;
	localparam int RADIX_W = 6;
	localparam int BASE_W = $clog2(MAX_RADIX + 1);
	localparam int DIGIT_W = $clog2(MAX_RADIX);
	localparam int REM_W = BASE_W + 1;
	localparam int CNT_W = $clog2(MAX_DIGITS + 1);
	localparam int IDX_W = $clog2(MAX_DIGITS);
	localparam int RECIP_W = NUM_W;
	localparam int CFG_DW = 64;
	localparam int CFG_AW = 6;
	localparam int ADDR_LSB = 3;
	localparam int REG_IDX_W = CFG_AW - ADDR_LSB;
	localparam int ALPHA_WORDS = 4;
	localparam int ALPHA_SEL_W = $clog2(ALPHA_WORDS);
	localparam int ALPHA_BITS = ALPHA_WORDS * CFG_DW;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
	localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(MAX_RADIX);
	localparam logic [CNT_W-1:0] DIGITS_FULL = CNT_W'(MAX_DIGITS);
	localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_RADIX   = 3'd0,
		REG_ALPHA_0 = 3'd1,
		REG_ALPHA_1 = 3'd2,
		REG_ALPHA_2 = 3'd3,
		REG_ALPHA_3 = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		JOB_ERROR,
		JOB_ZERO,
		JOB_CONVERT
	} job_kind_t;

	typedef struct packed {
		job_kind_t kind;
		logic negative;
		logic [NUM_W-1:0] magnitude;
		logic [BASE_W-1:0] base;
	} job_t;

	// floor(2^32 / base); the estimate floor(m * r / 2^32) is the quotient or one less
	localparam logic [RECIP_W-1:0] RECIP [0:MAX_RADIX] = '{
		32'h00000000, 32'h00000000, 32'h80000000, 32'h55555555,
		32'h40000000, 32'h33333333, 32'h2aaaaaaa, 32'h24924924,
		32'h20000000, 32'h1c71c71c, 32'h19999999, 32'h1745d174,
		32'h15555555, 32'h13b13b13, 32'h12492492, 32'h11111111,
		32'h10000000, 32'h0f0f0f0f, 32'h0e38e38e, 32'h0d79435e,
		32'h0ccccccc, 32'h0c30c30c, 32'h0ba2e8ba, 32'h0b21642c,
		32'h0aaaaaaa, 32'h0a3d70a3, 32'h09d89d89, 32'h097b425e,
		32'h09249249, 32'h08d3dcb0, 32'h08888888, 32'h08421084,
		32'h08000000
	};
endpackage
`default_nettype wire

[rtl/core/irad_if.sv]
// stream interfaces for input numbers and output characters
`default_nettype none
interface irad_num_if;
	logic valid;
	logic ready;
	logic signed [irad_pkg::NUM_W-1:0] number;

	modport source (output valid, output number, input ready);
	modport sink (input valid, input number, output ready);
endinterface

interface irad_chr_if;
	logic valid;
	logic ready;
	logic [irad_pkg::CHAR_W-1:0] character;
	logic last;
	logic error;

	modport source (output valid, output character, output last, output error, input ready);
	modport sink (input valid, input character, input last, input error, output ready);
endinterface
`default_nettype wire

[rtl/core/irad_regs.sv]
// apb configuration registers: radix and alphabet
`default_nettype none
module irad_regs (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [irad_pkg::CFG_AW-1:0] paddr,
	input  wire logic [irad_pkg::CFG_DW-1:0] pwdata,
	output logic [irad_pkg::CFG_DW-1:0] prdata,
	output logic pready,
	output logic [irad_pkg::RADIX_W-1:0] radix,
	output logic [irad_pkg::ALPHA_BITS-1:0] alphabet
);
	logic [irad_pkg::RADIX_W-1:0] radix_q;
	logic [irad_pkg::CFG_DW-1:0] alpha_q [irad_pkg::ALPHA_WORDS];
	irad_pkg::reg_idx_t idx;
	logic [irad_pkg::ALPHA_SEL_W-1:0] alpha_sel;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;
	assign idx = irad_pkg::reg_idx_t'(paddr[irad_pkg::CFG_AW-1:irad_pkg::ADDR_LSB]);
	assign alpha_sel = irad_pkg::ALPHA_SEL_W'(idx - irad_pkg::REG_ALPHA_0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= irad_pkg::RADIX_RESET;
			for (int w = 0; w < irad_pkg::ALPHA_WORDS; w++) begin
				alpha_q[w] <= '0;
			end
		end else if (wr_en) begin
			unique case (idx) inside
				irad_pkg::REG_RADIX: begin
					radix_q <= pwdata[irad_pkg::RADIX_W-1:0];
				end
				[irad_pkg::REG_ALPHA_0:irad_pkg::REG_ALPHA_3]: begin
					alpha_q[alpha_sel] <= pwdata;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx) inside
			irad_pkg::REG_RADIX: prdata = {{(irad_pkg::CFG_DW-irad_pkg::RADIX_W){1'b0}}, radix_q};
			[irad_pkg::REG_ALPHA_0:irad_pkg::REG_ALPHA_3]: prdata = alpha_q[alpha_sel];
			default: prdata = '0;
		endcase
	end

	assign radix = radix_q;
	for (genvar w = 0; w < irad_pkg::ALPHA_WORDS; w++) begin : g_alpha
		assign alphabet[w*irad_pkg::CFG_DW +: irad_pkg::CFG_DW] = alpha_q[w];
	end
endmodule
`default_nettype wire

[rtl/core/irad_front.sv]
// front end: accepts numbers, classifies them and forms the magnitude
`default_nettype none
module irad_front (
	irad_num_if.sink numbers,
	input  wire logic [irad_pkg::RADIX_W-1:0] radix,
	output logic push_valid,
	output irad_pkg::job_t push_job,
	input  wire logic push_ready
);
	logic [irad_pkg::NUM_W-1:0] raw;
	logic [irad_pkg::BASE_W-1:0] base;
	logic neg;

	assign raw = $unsigned(numbers.number);
	assign neg = raw[irad_pkg::NUM_W-1];
	// radix above the alphabet size saturates
	assign base = (radix > irad_pkg::BASE_MAX) ? irad_pkg::BASE_MAX : radix[irad_pkg::BASE_W-1:0];

	always_comb begin
		push_job.base = base;
		push_job.negative = neg;
		// unsigned negate also covers the most negative input
		push_job.magnitude = neg ? (irad_pkg::NUM_W'(0) - raw) : raw;
		if (base == '0) begin
			push_job.kind = irad_pkg::JOB_ERROR;
		end else if (raw == '0) begin
			push_job.kind = irad_pkg::JOB_ZERO;
		end else if (base == irad_pkg::BASE_W'(1)) begin
			push_job.kind = irad_pkg::JOB_ERROR;
		end else begin
			push_job.kind = irad_pkg::JOB_CONVERT;
		end
	end

	assign push_valid = numbers.valid;
	assign numbers.ready = push_ready;
endmodule
`default_nettype wire

[rtl/core/irad_queue.sv]
// short job queue between front end and digit engine
`default_nettype none
module irad_queue (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	input  wire irad_pkg::job_t push_job,
	output logic push_ready,
	output logic pop_valid,
	output irad_pkg::job_t pop_job,
	input  wire logic pop_ready
);
	irad_pkg::job_t slots_q [irad_pkg::QUEUE_DEPTH];
	logic [irad_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [irad_pkg::QCNT_W-1:0] count_q;
	logic do_push, do_pop;

	assign push_ready = count_q != irad_pkg::QCNT_W'(irad_pkg::QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_job = slots_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == irad_pkg::QPTR_W'(irad_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + irad_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == irad_pkg::QPTR_W'(irad_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + irad_pkg::QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + irad_pkg::QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - irad_pkg::QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end
endmodule
`default_nettype wire

[rtl/core/irad_back.sv]
// digit engine: reciprocal division per digit, then character output
`default_nettype none
`include "assert_macros.svh"
module irad_back (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic job_valid,
	input  wire irad_pkg::job_t job,
	output logic job_ready,
	input  wire logic [irad_pkg::ALPHA_BITS-1:0] alphabet,
	irad_chr_if.source chars
);
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic [irad_pkg::NUM_W-1:0] mag_q;
	logic [irad_pkg::BASE_W-1:0] base_q;
	logic neg_q;
	logic minus_pending_q;
	logic [irad_pkg::NUM_W-1:0] qest_q;
	logic [irad_pkg::CNT_W-1:0] cnt_q;
	logic [irad_pkg::DIGIT_W-1:0] digits_q [irad_pkg::MAX_DIGITS];
	logic out_valid_q, out_last_q, out_err_q;
	logic [irad_pkg::CHAR_W-1:0] out_char_q;

	logic out_free;
	logic out_load;
	logic [2*irad_pkg::NUM_W-1:0] prod;
	logic [irad_pkg::NUM_W+irad_pkg::BASE_W-1:0] qb;
	logic [irad_pkg::REM_W-1:0] rem_raw, rem_fix;
	logic fix;
	logic [irad_pkg::DIGIT_W-1:0] digit;
	logic [irad_pkg::NUM_W-1:0] quot;
	logic [irad_pkg::CNT_W-1:0] cnt_inc, cnt_dec;
	logic [irad_pkg::DIGIT_W-1:0] rd_digit;
	logic [irad_pkg::DIGIT_W+2:0] sel;
	logic [irad_pkg::CHAR_W-1:0] digit_char;

	assign out_free = !out_valid_q || chars.ready;
	assign job_ready = (state_q == ST_IDLE) && out_free;

	// a new result enters the output register this cycle
	assign out_load = ((state_q == ST_IDLE) && job_valid && job_ready &&
		(job.kind != irad_pkg::JOB_CONVERT)) || ((state_q == ST_EMIT) && out_free);

	// quotient estimate from the reciprocal table
	assign prod = {{irad_pkg::NUM_W{1'b0}}, mag_q} *
		{{(2*irad_pkg::NUM_W-irad_pkg::RECIP_W){1'b0}}, irad_pkg::RECIP[base_q]};

	// remainder is below twice the base, so the low bits are exact
	assign qb = {{irad_pkg::BASE_W{1'b0}}, qest_q} * {{irad_pkg::NUM_W{1'b0}}, base_q};
	assign rem_raw = mag_q[irad_pkg::REM_W-1:0] - qb[irad_pkg::REM_W-1:0];
	assign fix = rem_raw >= {1'b0, base_q};
	assign rem_fix = rem_raw - {1'b0, base_q};
	assign digit = fix ? rem_fix[irad_pkg::DIGIT_W-1:0] : rem_raw[irad_pkg::DIGIT_W-1:0];
	assign quot = qest_q + {{(irad_pkg::NUM_W-1){1'b0}}, fix};

	assign cnt_inc = cnt_q + irad_pkg::CNT_W'(1);
	assign cnt_dec = cnt_q - irad_pkg::CNT_W'(1);
	assign rd_digit = digits_q[cnt_dec[irad_pkg::IDX_W-1:0]];
	assign sel = {rd_digit, 3'b000};
	assign digit_char = alphabet[sel +: irad_pkg::CHAR_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mag_q <= '0;
			base_q <= '0;
			neg_q <= 1'b0;
			minus_pending_q <= 1'b0;
			qest_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
			out_last_q <= 1'b0;
			out_err_q <= 1'b0;
			out_char_q <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (chars.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid && job_ready) begin
						unique case (job.kind)
							irad_pkg::JOB_ERROR: begin
								out_char_q <= '0;
								out_last_q <= 1'b1;
								out_err_q <= 1'b1;
							end
							irad_pkg::JOB_ZERO: begin
								out_char_q <= irad_pkg::CH_ZERO;
								out_last_q <= 1'b1;
								out_err_q <= 1'b0;
							end
							irad_pkg::JOB_CONVERT: begin
								mag_q <= job.magnitude;
								base_q <= job.base;
								neg_q <= job.negative;
								cnt_q <= '0;
								state_q <= ST_MUL;
							end
							default: begin
							end
						endcase
					end
				end
				ST_MUL: begin
					qest_q <= prod[2*irad_pkg::NUM_W-1:irad_pkg::NUM_W];
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					mag_q <= quot;
					cnt_q <= cnt_inc;
					if (quot == '0 || cnt_inc == irad_pkg::DIGITS_FULL) begin
						minus_pending_q <= neg_q;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_err_q <= 1'b0;
						if (minus_pending_q) begin
							minus_pending_q <= 1'b0;
							out_char_q <= irad_pkg::CH_MINUS;
							out_last_q <= 1'b0;
						end else begin
							out_char_q <= digit_char;
							out_last_q <= cnt_q == irad_pkg::CNT_W'(1);
							cnt_q <= cnt_dec;
							if (cnt_q == irad_pkg::CNT_W'(1)) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// digits are collected least significant first
	always_ff @(posedge clk) begin
		if (state_q == ST_DIV) begin
			digits_q[cnt_q[irad_pkg::IDX_W-1:0]] <= digit;
		end
	end

	assign chars.valid = out_valid_q;
	assign chars.character = out_char_q;
	assign chars.last = out_last_q;
	assign chars.error = out_err_q;

	`ASSERT_HOLDS(a_cnt_range, clk, arst_n, cnt_q <= irad_pkg::DIGITS_FULL, "digit count beyond store")
	`ASSERT_IMPLIES(a_emit_cnt, clk, arst_n, state_q == ST_EMIT, cnt_q != '0, "emit with no digits")
	`ASSERT_IMPLIES(a_err_form, clk, arst_n, out_valid_q && out_err_q, out_last_q && out_char_q == '0, "bad error result")
	`ASSERT_NEXT(a_start_conv, clk, arst_n, job_valid && job_ready && job.kind == irad_pkg::JOB_CONVERT, state_q == ST_MUL, "conversion did not start")
endmodule
`default_nettype wire

[rtl/core/integer_to_radix_digits.sv]
// top level: signed integer to text in a configured radix
//
// numbers: valid/ready stream of signed 32-bit values; chars: valid/ready stream
// of result characters, most significant first, last on the final one, and error on
// the single result for radix 0, or radix 1 with nonzero input; else zero gives '0'.
// apb port: radix at 0x00, alphabet words 0..3 at 0x08..0x20; the user must see that
// they are written only while idle, as the block itself does not enforce it.
// a front end classifies each number and takes its magnitude into a two-entry
// job queue, so up to two numbers are taken while a conversion is running.
// for each digit the engine runs a reciprocal multiply step, then a remainder and
// correction step; the characters then pass through the output register, one per
// cycle while the receiver is ready.
// error and zero results leave in the cycle after the job is taken.
// reset clears the queue, the engine and the output register, sets the radix
// to ten and the alphabet to zero bytes; no clearing pass is needed.
// when the receiver stalls the pending character holds, the engine waits and
// the queue fills, after which numbers.ready drops.
`default_nettype none
module integer_to_radix_digits (
	input  wire logic clk,
	input  wire logic arst_n,
	irad_num_if.sink numbers,
	irad_chr_if.source chars,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [irad_pkg::CFG_AW-1:0] paddr,
	input  wire logic [irad_pkg::CFG_DW-1:0] pwdata,
	output logic [irad_pkg::CFG_DW-1:0] prdata,
	output logic pready
);
	logic [irad_pkg::RADIX_W-1:0] radix;
	logic [irad_pkg::ALPHA_BITS-1:0] alphabet;
	logic push_valid, push_ready, pop_valid, pop_ready;
	irad_pkg::job_t push_job, pop_job;

	irad_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.radix    (radix),
		.alphabet (alphabet)
	);

	irad_front u_front (
		.numbers    (numbers),
		.radix      (radix),
		.push_valid (push_valid),
		.push_job   (push_job),
		.push_ready (push_ready)
	);

	irad_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_job   (push_job),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_job    (pop_job),
		.pop_ready  (pop_ready)
	);

	irad_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (pop_valid),
		.job       (pop_job),
		.job_ready (pop_ready),
		.alphabet  (alphabet),
		.chars     (chars)
	);
endmodule
`default_nettype wire

[bench/integer_to_radix_digits_tb.sv]
`timescale 1ns / 1ps
// self-checking testbench for the signed integer to radix text converter
module integer_to_radix_digits_tb;
	import irad_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam int SETTLE_CYCLES = 120;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int PHASES = 9;
	localparam int ITEMS_PER_PHASE = 30;
	// "0123456789abcdefghijklmnopqrstuv", character i in byte i
	localparam logic [CFG_DW-1:0] TEXT_ALPHABET [ALPHA_WORDS] = '{
		64'h3736353433323130, 64'h6665646362613938,
		64'h6e6d6c6b6a696867, 64'h767574737271706f
	};

	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic last;
		logic error;
	} char_result_t;

	class text_scoreboard;
		logic [RADIX_W-1:0] radix;
		logic [CFG_DW-1:0] alphabet [ALPHA_WORDS];
		char_result_t expected_text [$];
		int mismatches;

		function new();
			radix = RADIX_RESET;
			foreach (alphabet[w]) alphabet[w] = '0;
			mismatches = 0;
		endfunction

		function void set_register(reg_idx_t idx, logic [CFG_DW-1:0] value);
			if (idx == REG_RADIX)
				radix = value[RADIX_W-1:0];
			else
				alphabet[idx - REG_ALPHA_0] = value;
		endfunction

		function int pending();
			return expected_text.size();
		endfunction

		function void push_char(logic [CHAR_W-1:0] ch, logic last, logic error);
			char_result_t r;
			r.character = ch;
			r.last = last;
			r.error = error;
			expected_text.push_back(r);
		endfunction

		// predicts the text of one accepted number
		function void note_number(logic signed [NUM_W-1:0] number);
			logic [NUM_W-1:0] mag;
			logic [RADIX_W-1:0] base;
			logic [DIGIT_W-1:0] digits [$];
			logic [DIGIT_W-1:0] d;
			base = (radix > MAX_RADIX) ? RADIX_W'(MAX_RADIX) : radix;
			if (base == 0 || (base == 1 && number != 0)) begin
				push_char('0, 1'b1, 1'b1);
				return;
			end
			if (number == 0) begin
				push_char(CH_ZERO, 1'b1, 1'b0);
				return;
			end
			// unsigned magnitude, so the most negative value converts too
			mag = number[NUM_W-1] ? -number : number;
			while (mag != 0 && digits.size() < MAX_DIGITS) begin
				digits.push_front(DIGIT_W'(mag % base));
				mag = mag / base;
			end
			if (number[NUM_W-1])
				push_char(CH_MINUS, 1'b0, 1'b0);
			foreach (digits[i]) begin
				d = digits[i];
				push_char(alphabet[d / 8][8 * (d % 8) +: CHAR_W], i == digits.size() - 1, 1'b0);
			end
		endfunction

		function void check_char(logic [CHAR_W-1:0] ch, logic last, logic error);
			char_result_t want;
			if (expected_text.size() == 0) begin
				$error("unexpected character transfer: character %h last %b error %b",
					ch, last, error);
				mismatches++;
				return;
			end
			want = expected_text.pop_front();
			if (ch !== want.character) begin
				$error("character: expected %h, got %h", want.character, ch);
				mismatches++;
			end
			if (last !== want.last) begin
				$error("last: expected %b, got %b", want.last, last);
				mismatches++;
			end
			if (error !== want.error) begin
				$error("error: expected %b, got %b", want.error, error);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [CFG_DW-1:0] pwdata;
	logic [CFG_DW-1:0] prdata;
	logic pready;

	irad_num_if num_bus ();
	irad_chr_if chr_bus ();

	integer_to_radix_digits dut (
		.clk(clk),
		.arst_n(arst_n),
		.numbers(num_bus),
		.chars(chr_bus),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	text_scoreboard store = new();
	int src_gap_pct = 0;
	int sink_stall_pct = 0;
	bit long_hold_req = 1'b0;

	always begin
		clk = 1'b1;
		#HALF_PERIOD;
		clk = 1'b0;
		#HALF_PERIOD;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(20, 60);
		return $urandom_range(1, 3);
	endfunction

	function automatic logic [RADIX_W-1:0] pick_radix();
		case ($urandom_range(0, 9))
			0: return RADIX_W'($urandom_range(0, 1));
			1: return RADIX_W'($urandom_range(MAX_RADIX + 1, 63));
			2: return RADIX_W'(MAX_RADIX);
			3: return RADIX_W'(2);
			default: return RADIX_W'($urandom_range(2, MAX_RADIX - 1));
		endcase
	endfunction

	function automatic logic signed [NUM_W-1:0] pick_number();
		case ($urandom_range(0, 9))
			0: return '0;
			1: begin
				case ($urandom_range(0, 3))
					0: return 32'sh80000000;
					1: return 32'sh7fffffff;
					2: return -32'sd1;
					default: return 32'sd1;
				endcase
			end
			2, 3: return NUM_W'($urandom_range(0, 200)) - 32'sd100;
			4: return -$signed(NUM_W'($urandom_range(0, 100000)));
			default: return $signed($urandom);
		endcase
	endfunction

	// entered and left at a falling edge
	task automatic apb_write(reg_idx_t idx, logic [CFG_DW-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, {ADDR_LSB{1'b0}}};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		store.set_register(idx, value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	// entered and left at a falling edge; valid stays high for the next number
	task automatic send_number(logic signed [NUM_W-1:0] number);
		int gap;
		gap = ($urandom_range(0, 99) < src_gap_pct) ? pick_gap() : 0;
		if (gap > 0) begin
			num_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		num_bus.valid <= 1'b1;
		num_bus.number <= number;
		do @(posedge clk); while (!num_bus.ready);
		store.note_number(number);
		@(negedge clk);
	endtask

	// wait for every expected character, then let the engine go quiet
	task automatic settle();
		num_bus.valid <= 1'b0;
		while (store.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic load_alphabet(bit text_form);
		for (int w = 0; w < ALPHA_WORDS; w++)
			apb_write(reg_idx_t'(REG_ALPHA_0 + w), text_form ? TEXT_ALPHABET[w] : {$urandom, $urandom});
	endtask

	always @(posedge clk) begin
		if (arst_n && chr_bus.valid && chr_bus.ready)
			store.check_char(chr_bus.character, chr_bus.last, chr_bus.error);
	end

	initial begin : receiver
		int stall;
		stall = 0;
		chr_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall = LONG_HOLD_CYCLES;
			end else if (stall == 0 && $urandom_range(0, 99) < sink_stall_pct) begin
				stall = pick_gap();
			end
			if (stall > 0) begin
				chr_bus.ready <= 1'b0;
				stall--;
			end else begin
				chr_bus.ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		bit text_form;
		arst_n = 1'b0;
		num_bus.valid = 1'b0;
		num_bus.number = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		src_gap_pct = 30;
		sink_stall_pct = 30;
		// reset radix ten, alphabet still all zero bytes; zero still gives '0'
		send_number('0);
		send_number(32'sd10);
		settle();
		load_alphabet(1'b1);
		send_number('0);
		send_number(32'sd1);
		send_number(-32'sd1);
		send_number(32'sh7fffffff);
		send_number(32'sh80000000);
		send_number(32'sd12345);
		send_number(-32'sd987);
		settle();
		// base two: the most negative value gives the longest text
		apb_write(REG_RADIX, 64'd2);
		send_number(32'sh80000000);
		send_number(32'sh7fffffff);
		send_number(-32'sd1);
		settle();
		apb_write(REG_RADIX, 64'd0);
		send_number('0);
		send_number(32'sd5);
		send_number(-32'sd5);
		settle();
		// radix one flags an error except for zero
		apb_write(REG_RADIX, 64'd1);
		send_number('0);
		send_number(32'sd1);
		send_number(32'sh80000000);
		settle();
		// all radix bits set: saturates to the largest base
		apb_write(REG_RADIX, 64'd63);
		send_number(32'sh80000000);
		send_number(32'sh7fffffff);
		send_number(32'sd31);
		send_number(32'sd32);
		settle();

		for (int p = 0; p < PHASES; p++) begin
			settle();
			apb_write(REG_RADIX, {{(CFG_DW - RADIX_W){1'b0}}, pick_radix()});
			text_form = $urandom_range(0, 1);
			load_alphabet(text_form);
			src_gap_pct = (p % 3 == 0) ? 0 : $urandom_range(5, 60);
			sink_stall_pct = (p % 3 == 1) ? 0 : $urandom_range(5, 60);
			if (p == 2) begin
				// receiver stalls long while numbers keep coming back to back
				src_gap_pct = 0;
				long_hold_req = 1'b1;
			end
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (p == 5 && n == ITEMS_PER_PHASE / 2) begin
					num_bus.valid <= 1'b0;
					while (store.pending() != 0) @(negedge clk);
					@(negedge clk);
				end
				send_number(pick_number());
			end
		end

		settle();
		if (store.mismatches == 0) begin
			$display("PASS integer_to_radix_digits");
		end else begin
			$display("FAIL integer_to_radix_digits");
		end
		$finish;
	end

	initial begin : watchdog
		#50_000_000;
		$display("FAIL integer_to_radix_digits");
		$finish;
	end
endmodule

[sim.f]
+incdir+rtl/core
rtl/core/irad_pkg.sv
rtl/core/irad_if.sv
rtl/core/irad_regs.sv
rtl/core/irad_front.sv
rtl/core/irad_queue.sv
rtl/core/irad_back.sv
rtl/core/integer_to_radix_digits.sv
bench/integer_to_radix_digits_tb.sv
